/* sv/assert_macros.svh */
// Assertion macros shared by the interval symbol table RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define IST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent implies a consequent on the same edge.
`define IST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/ist_pkg.sv */
// Shared constants for the interval symbol table: default sizes, field widths,
// opcode and status codes. No dependencies.
package ist_pkg;

  localparam int unsigned IST_DEPTH       = 64;
  localparam int unsigned IST_OFFSET_BITS = 32;

  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned ENTRY_OFF_W = 32;
  localparam int unsigned USED_W      = 33;

  localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_USED   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_LIST   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COVERED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

/* sv/interval_symbol_table_core.sv */
// Interval symbol table: a sorted table of (start, size, symbol) entries held in one RAM.
// One request at a time. Lookup is a linear scan of the RAM, one entry per cycle, set by
// its single read port; add and remove may also shift the entries behind the insert or
// remove point, and list returns one entry per response, holding while the output is stalled.
// The default table holds 64 entries. Depends on ist_pkg, ist_ram and assert_macros.svh.
`include "assert_macros.svh"
module interval_symbol_table_core
  import ist_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = IST_DEPTH,
  parameter int unsigned OFFSET_BITS = IST_OFFSET_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OPCODE_W-1:0]    opcode,
  input  logic [31:0]            offset,
  input  logic [SIZE_W-1:0]      symbol_size,
  input  logic [ID_W-1:0]        symbol_id,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    status,
  output logic                   found,
  output logic [ENTRY_OFF_W-1:0] entry_offset,
  output logic [SIZE_W-1:0]      entry_size,
  output logic [ID_W-1:0]        entry_symbol,
  output logic [USED_W-1:0]      used_size,
  output logic                   last
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned UW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;
  localparam int unsigned RW = OFFSET_BITS + SIZE_W + ID_W;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_SCAN      = 9'b000000010,
    S_SHIFT     = 9'b000000100,
    S_WRNEW     = 9'b000001000,
    S_USED_RD   = 9'b000010000,
    S_USED_WAIT = 9'b000100000,
    S_LIST_RD   = 9'b001000000,
    S_LIST_WAIT = 9'b010000000,
    S_RESP      = 9'b100000000
  } state_t;

  state_t                 state;
  logic [OPCODE_W-1:0]    op;
  logic [OFFSET_BITS-1:0] off_q;
  logic [SIZE_W-1:0]      sz_q;
  logic [ID_W-1:0]        id_q;
  logic [CW-1:0]          count;
  logic [USED_W-1:0]      used_q;
  logic [CW-1:0]          ptr;
  logic [CW-1:0]          left;
  logic                   rv;
  logic [IW-1:0]          rv_addr;
  logic                   dir;
  logic                   ins_mode;
  logic [IW-1:0]          wr_pos;
  logic                   cand_v;
  logic [IW-1:0]          cand_idx;
  logic [OFFSET_BITS-1:0] cand_start;
  logic [SIZE_W-1:0]      cand_len;
  logic [ID_W-1:0]        cand_sym;
  logic [STATUS_W-1:0]    res_status;
  logic                   res_found;
  logic [ENTRY_OFF_W-1:0] res_off;
  logic [SIZE_W-1:0]      res_size;
  logic [ID_W-1:0]        res_sym;
  logic                   res_last;

  logic                   we;
  logic [IW-1:0]          waddr;
  logic [RW-1:0]          wdata;
  logic [IW-1:0]          raddr;
  logic [RW-1:0]          rdata;

  logic [UW-1:0]          off_w;
  logic [OFFSET_BITS-1:0] off_in;
  logic [OFFSET_BITS-1:0] r_start;
  logic [SIZE_W-1:0]      r_len;
  logic [ID_W-1:0]        r_id;
  logic [UW-1:0]          r_start_w;
  logic [UW-1:0]          cand_start_w;
  logic [UW-1:0]          cand_end;
  logic [UW-1:0]          r_end;
  logic                   covered;
  logic                   eq_hit;
  logic [CW-1:0]          ins_pos;
  logic                   issue;
  logic                   stream_done;
  logic [CW-1:0]          cnt_m1;

  ist_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign off_w        = UW'(offset);
  assign off_in       = off_w[OFFSET_BITS-1:0];
  assign r_start      = rdata[RW-1 -: OFFSET_BITS];
  assign r_len        = rdata[SIZE_W+ID_W-1:ID_W];
  assign r_id         = rdata[ID_W-1:0];
  assign r_start_w    = UW'(r_start);
  assign cand_start_w = UW'(cand_start);
  assign cand_end     = cand_start_w + UW'(cand_len);
  assign r_end        = r_start_w + UW'(r_len);
  assign covered      = cand_v && (UW'(off_q) < cand_end);
  assign eq_hit       = cand_v && (cand_start == off_q);
  assign ins_pos      = cand_v ? (CW'(cand_idx) + CW'(1)) : '0;
  assign issue        = ((state == S_SCAN) || (state == S_SHIFT)) && (left != '0);
  assign stream_done  = (left == '0) && !rv;
  assign cnt_m1       = count - CW'(1);

  always_comb begin
    raddr = (state == S_USED_RD) ? cnt_m1[IW-1:0] : ptr[IW-1:0];
    we    = 1'b0;
    waddr = wr_pos;
    wdata = {off_q, sz_q, id_q};
    if ((state == S_SHIFT) && rv) begin
      we    = 1'b1;
      waddr = dir ? (rv_addr + IW'(1)) : (rv_addr - IW'(1));
      wdata = rdata;
    end else if (state == S_WRNEW) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      used_q <= '0;
      rv     <= 1'b0;
      left   <= '0;
      cand_v <= 1'b0;
    end else begin
      rv      <= issue;
      rv_addr <= ptr[IW-1:0];
      if (issue) begin
        ptr  <= dir ? (ptr - CW'(1)) : (ptr + CW'(1));
        left <= left - CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= opcode;
            off_q      <= off_in;
            sz_q       <= symbol_size;
            id_q       <= symbol_id;
            cand_v     <= 1'b0;
            ptr        <= '0;
            left       <= count;
            dir        <= 1'b0;
            res_status <= ST_OK;
            res_found  <= 1'b0;
            res_off    <= '0;
            res_size   <= '0;
            res_sym    <= '0;
            res_last   <= 1'b1;
            if (opcode == OP_ADD || opcode == OP_REMOVE || opcode == OP_LOOKUP) begin
              state <= S_SCAN;
            end else if (opcode == OP_USED) begin
              state <= S_RESP;
            end else if (opcode == OP_LIST) begin
              state <= (count == '0) ? S_RESP : S_LIST_RD;
            end else begin
              res_status <= ST_NOT_FOUND;
              state      <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          if (rv && (r_start <= off_q)) begin
            cand_v     <= 1'b1;
            cand_idx   <= rv_addr;
            cand_start <= r_start;
            cand_len   <= r_len;
            cand_sym   <= r_id;
          end
          if (stream_done) begin
            if (op == OP_LOOKUP || op == OP_REMOVE) begin
              if (!covered) begin
                res_status <= ST_NOT_FOUND;
                state      <= S_RESP;
              end else begin
                res_found <= 1'b1;
                res_off   <= cand_start_w[ENTRY_OFF_W-1:0];
                res_size  <= cand_len;
                res_sym   <= cand_sym;
                if (op == OP_LOOKUP) begin
                  state <= S_RESP;
                end else if (cnt_m1 == CW'(cand_idx)) begin
                  count <= cnt_m1;
                  state <= S_USED_RD;
                end else begin
                  ptr   <= CW'(cand_idx) + CW'(1);
                  left  <= cnt_m1 - CW'(cand_idx);
                  dir   <= 1'b0;
                  state <= S_SHIFT;
                end
              end
            end else if (covered) begin
              res_status <= ST_COVERED;
              res_found  <= 1'b1;
              res_off    <= cand_start_w[ENTRY_OFF_W-1:0];
              res_size   <= cand_len;
              res_sym    <= cand_sym;
              state      <= S_RESP;
            end else if (eq_hit) begin
              wr_pos   <= cand_idx;
              ins_mode <= 1'b0;
              state    <= S_WRNEW;
            end else if (count == CW'(TABLE_DEPTH)) begin
              res_status <= ST_FULL;
              state      <= S_RESP;
            end else begin
              wr_pos   <= ins_pos[IW-1:0];
              ins_mode <= 1'b1;
              if (count == ins_pos) begin
                state <= S_WRNEW;
              end else begin
                ptr   <= cnt_m1;
                left  <= count - ins_pos;
                dir   <= 1'b1;
                state <= S_SHIFT;
              end
            end
          end
        end
        S_SHIFT: begin
          if (stream_done) begin
            if (dir) begin
              state <= S_WRNEW;
            end else begin
              count <= cnt_m1;
              state <= S_USED_RD;
            end
          end
        end
        S_WRNEW: begin
          if (ins_mode) begin
            count <= count + CW'(1);
          end
          state <= S_USED_RD;
        end
        S_USED_RD: begin
          if (count == '0) begin
            used_q <= '0;
            state  <= S_RESP;
          end else begin
            state <= S_USED_WAIT;
          end
        end
        S_USED_WAIT: begin
          used_q <= r_end[USED_W-1:0];
          state  <= S_RESP;
        end
        S_LIST_RD: begin
          state <= S_LIST_WAIT;
        end
        S_LIST_WAIT: begin
          res_status <= ST_OK;
          res_found  <= 1'b1;
          res_off    <= r_start_w[ENTRY_OFF_W-1:0];
          res_size   <= r_len;
          res_sym    <= r_id;
          res_last   <= (ptr + CW'(1)) == count;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (out_ready) begin
            if (op == OP_LIST && !res_last) begin
              ptr   <= ptr + CW'(1);
              state <= S_LIST_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready     = (state == S_IDLE);
  assign out_valid    = (state == S_RESP);
  assign status       = res_status;
  assign found        = res_found;
  assign entry_offset = res_off;
  assign entry_size   = res_size;
  assign entry_symbol = res_sym;
  assign used_size    = used_q;
  assign last         = res_last;

  `IST_ASSERT(a_count_bound, count <= CW'(TABLE_DEPTH), "entry count above table depth")
  `IST_ASSERT(a_one_side, !(in_ready && out_valid), "request taken while result pending")
  `IST_ASSERT_IMPL(a_write_state, we, (state == S_SHIFT) || (state == S_WRNEW), "stray RAM write")
  `IST_ASSERT_IMPL(a_shift_read, (state == S_SHIFT) && rv, $past(issue), "shift data without read")

endmodule

/* sv/ist_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ist_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* dv/interval_symbol_table_core_tb.sv */
// Self-checking bench for interval_symbol_table_core: directed and random requests with
// a scoreboard that mirrors the sorted table. Depends on ist_pkg and the core RTL.
module interval_symbol_table_core_tb
  import ist_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_REQS   = 400;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   found;
    logic [ENTRY_OFF_W-1:0] eoff;
    logic [SIZE_W-1:0]      esize;
    logic [ID_W-1:0]        esym;
    logic [USED_W-1:0]      used;
    logic                   last;
  } table_result_t;

  class table_scoreboard;
    logic [31:0]       starts[IST_DEPTH];
    logic [SIZE_W-1:0] sizes[IST_DEPTH];
    logic [ID_W-1:0]   idents[IST_DEPTH];
    int                count;
    table_result_t     awaited[$];
    int                errors;
    int                results_seen;

    function new();
      count = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void add_awaited(table_result_t r);
      awaited.insert(awaited.size(), r);
    endfunction

    function logic [USED_W-1:0] table_end();
      if (count == 0) return '0;
      return {1'b0, starts[count-1]} + sizes[count-1];
    endfunction

    function int covering(logic [31:0] off);
      int i;
      i = count;
      while (i > 0 && starts[i-1] > off) i--;
      if (i == 0) return -1;
      i--;
      if ({1'b0, off} < {1'b0, starts[i]} + sizes[i]) return i;
      return -1;
    endfunction

    function table_result_t make(logic [STATUS_W-1:0] st, int idx, logic lst);
      table_result_t r;
      r = '0;
      r.status = st;
      if (idx >= 0) begin
        r.found = 1'b1;
        r.eoff = starts[idx];
        r.esize = sizes[idx];
        r.esym = idents[idx];
      end
      r.used = table_end();
      r.last = lst;
      return r;
    endfunction

    function void note_request(logic [2:0] op, logic [31:0] off, logic [15:0] sz,
                               logic [15:0] id);
      int idx;
      int pos;
      table_result_t r;
      case (op)
        OP_ADD: begin
          idx = covering(off);
          if (idx >= 0) begin
            add_awaited(make(ST_COVERED, idx, 1'b1));
          end else begin
            pos = 0;
            while (pos < count && starts[pos] < off) pos++;
            if (pos < count && starts[pos] == off) begin
              sizes[pos] = sz;
              idents[pos] = id;
              add_awaited(make(ST_OK, -1, 1'b1));
            end else if (count >= IST_DEPTH) begin
              add_awaited(make(ST_FULL, -1, 1'b1));
            end else begin
              for (int i = count; i > pos; i--) begin
                starts[i] = starts[i-1];
                sizes[i] = sizes[i-1];
                idents[i] = idents[i-1];
              end
              starts[pos] = off;
              sizes[pos] = sz;
              idents[pos] = id;
              count++;
              add_awaited(make(ST_OK, -1, 1'b1));
            end
          end
        end
        OP_REMOVE: begin
          idx = covering(off);
          if (idx < 0) begin
            add_awaited(make(ST_NOT_FOUND, -1, 1'b1));
          end else begin
            r = make(ST_OK, idx, 1'b1);
            for (int i = idx; i + 1 < count; i++) begin
              starts[i] = starts[i+1];
              sizes[i] = sizes[i+1];
              idents[i] = idents[i+1];
            end
            count--;
            r.used = table_end();
            add_awaited(r);
          end
        end
        OP_LOOKUP: begin
          idx = covering(off);
          add_awaited(make(idx >= 0 ? ST_OK : ST_NOT_FOUND, idx, 1'b1));
        end
        OP_USED: add_awaited(make(ST_OK, -1, 1'b1));
        OP_LIST: begin
          if (count == 0) add_awaited(make(ST_OK, -1, 1'b1));
          for (int i = 0; i < count; i++)
            add_awaited(make(ST_OK, i, i + 1 == count));
        end
        default: add_awaited(make(ST_NOT_FOUND, -1, 1'b1));
      endcase
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %h actual %h", $time, want.status, got.status);
        errors++;
      end
      if (got.found !== want.found) begin
        $display("%0t: found expected %h actual %h", $time, want.found, got.found);
        errors++;
      end
      if (got.eoff !== want.eoff) begin
        $display("%0t: entry_offset expected %h actual %h", $time, want.eoff, got.eoff);
        errors++;
      end
      if (got.esize !== want.esize) begin
        $display("%0t: entry_size expected %h actual %h", $time, want.esize, got.esize);
        errors++;
      end
      if (got.esym !== want.esym) begin
        $display("%0t: entry_symbol expected %h actual %h", $time, want.esym, got.esym);
        errors++;
      end
      if (got.used !== want.used) begin
        $display("%0t: used_size expected %h actual %h", $time, want.used, got.used);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %h actual %h", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [OPCODE_W-1:0]    opcode;
  logic [31:0]            offset;
  logic [SIZE_W-1:0]      symbol_size;
  logic [ID_W-1:0]        symbol_id;
  logic                   out_valid;
  logic                   out_ready;
  logic [STATUS_W-1:0]    status;
  logic                   found;
  logic [ENTRY_OFF_W-1:0] entry_offset;
  logic [SIZE_W-1:0]      entry_size;
  logic [ID_W-1:0]        entry_symbol;
  logic [USED_W-1:0]      used_size;
  logic                   last;

  table_scoreboard sb;
  int unsigned     cycles;
  bit              quiet;
  int              requests_sent;
  bit              saw_full;

  interval_symbol_table_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .offset(offset), .symbol_size(symbol_size), .symbol_id(symbol_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .found(found), .entry_offset(entry_offset), .entry_size(entry_size),
    .entry_symbol(entry_symbol), .used_size(used_size), .last(last)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial sb = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("interval_symbol_table_core_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (status == ST_FULL) saw_full <= 1'b1;
      sb.check_result('{status, found, entry_offset, entry_size, entry_symbol,
                        used_size, last});
    end
    out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 18);
  end

  task automatic send(logic [2:0] op, logic [31:0] off, logic [15:0] sz, logic [15:0] id);
    in_valid <= 1'b1;
    opcode <= op;
    offset <= off;
    symbol_size <= sz;
    symbol_id <= id;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, off, sz, id);
    requests_sent++;
    if (!quiet && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_offset();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 4095);
    if (r < 90) return 32'hFFFF_F000 | $urandom_range(0, 4095);
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(1, 64));
    if (r < 98) return 16'($urandom_range(1, 65535));
    return 16'd0;
  endfunction

  task automatic random_request(int add_pct, int rem_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < add_pct)
      send(OP_ADD, pick_offset(), pick_size(), 16'($urandom_range(0, 65535)));
    else if (r < add_pct + rem_pct)
      send(OP_REMOVE, pick_offset(), 16'($urandom_range(0, 65535)),
           16'($urandom_range(0, 65535)));
    else if (r < 88)
      send(OP_LOOKUP, pick_offset(), 16'($urandom_range(0, 65535)),
           16'($urandom_range(0, 65535)));
    else if (r < 93)
      send(OP_USED, $urandom, 16'($urandom_range(0, 65535)),
           16'($urandom_range(0, 65535)));
    else if (r < 98)
      send(OP_LIST, $urandom, 16'($urandom_range(0, 65535)),
           16'($urandom_range(0, 65535)));
    else
      send(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), pick_offset(),
           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    cycles = 0;
    quiet = 1'b0;
    requests_sent = 0;
    saw_full = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    out_ready <= 1'b0;
    opcode <= OP_ADD;
    offset <= '0;
    symbol_size <= '0;
    symbol_id <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send(OP_LIST, 32'd0, 16'd0, 16'd0);
    send(OP_USED, 32'd0, 16'd0, 16'd0);
    send(OP_LOOKUP, 32'd0, 16'd0, 16'd0);
    send(OP_REMOVE, 32'd5, 16'd0, 16'd0);
    send(OP_ADD, 32'd100, 16'd16, 16'h1111);
    send(OP_ADD, 32'd108, 16'd4, 16'h2222);
    send(OP_ADD, 32'd0, 16'hFFFF, 16'hFFFF);
    send(OP_ADD, 32'hFFFF_FFF0, 16'hFFFF, 16'h0000);
    send(OP_ADD, 32'd50, 16'd200, 16'h3333);
    send(OP_LOOKUP, 32'hFFFF_FFFF, 16'd0, 16'd0);
    send(OP_LOOKUP, 32'd115, 16'd0, 16'd0);
    send(OP_LOOKUP, 32'd70000, 16'd0, 16'd0);
    send(OP_ADD, 32'd70000, 16'd0, 16'h4444);
    send(OP_LOOKUP, 32'd70000, 16'd0, 16'd0);
    send(OP_ADD, 32'd70000, 16'd8, 16'h5555);
    send(OP_LOOKUP, 32'd70007, 16'd0, 16'd0);
    send(OP_LIST, 32'd0, 16'd0, 16'd0);
    send(OP_REMOVE, 32'd104, 16'd0, 16'd0);
    send(OP_REMOVE, 32'd104, 16'd0, 16'd0);
    send(OP_SPARE_LO, 32'd0, 16'd0, 16'd0);
    send(OP_SPARE_HI, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send(OP_USED, 32'd0, 16'd0, 16'd0);
    send(OP_LIST, 32'd0, 16'd0, 16'd0);

    // fill the table, then drain it
    for (int n = 0; n < RAND_REQS; n++) begin
      quiet = (n >= 150 && n < 230);
      if (n < RAND_REQS / 2) random_request(60, 8);
      else random_request(20, 50);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d requests, %0d results checked; table full reached: %0d",
             requests_sent, sb.results_seen, saw_full);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("interval_symbol_table_core_tb OK");
    end else begin
      $display("interval_symbol_table_core_tb NOT OK");
    end
    $finish;
  end

endmodule
